/* rtl/polynomial_term_table_assert.svh */
// Assertion macros used by the checker of the polynomial term table.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef POLYNOMIAL_TERM_TABLE_ASSERT_SVH
`define POLYNOMIAL_TERM_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ptt_pkg.sv */
// Shared types and constants of the polynomial term table.
// Used by the top level and its checker; depends on nothing.
package ptt_pkg;

    // Default table size.
    localparam int MAX_TERMS_DEF = 64;

    // Fixed field widths.
    localparam int EXP_W     = 10;
    localparam int COEF_W    = 32;
    localparam int DEG_W     = 11;
    localparam int CNT_OUT_W = 7;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;

    // Operation codes.
    localparam t_mode MODE_APPEND = 2'd0;
    localparam t_mode MODE_LOOKUP = 2'd1;
    localparam t_mode MODE_CHANGE = 2'd2;

    // Result status codes.
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_NOMATCH = 2'd2;

    // Degree reported by an empty table.
    localparam logic signed [DEG_W-1:0] DEG_EMPTY = '1;

endpackage

/* rtl/ptt_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package needed.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read with the data held while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/polynomial_term_table.sv */
// Top level of the polynomial term table: sequencer, state and result register.
// Depends on ptt_pkg and ptt_ram.
//
// The input channel (i_in_valid / o_in_ready) carries one word per operation:
// append a term, look up the coefficient of the oldest term with an exponent,
// or change the coefficient of that term. The output channel
// (o_out_valid / i_out_ready) returns exactly one result word per input word,
// with the coefficient (lookups), found flag, status, degree and term count.
// An append, an unused mode and a search of an empty table finish in the
// cycle of acceptance, so the result is valid on the next cycle. A lookup or
// change scans the stored terms oldest first through the single read port of
// the term memory, one entry per cycle while the result register is free,
// and registers its result once a match or the newest entry is compared.
// With a ready receiver an append or unused word is taken every cycle; a
// scan takes no new word until its result is registered.
// Synchronous reset empties the table (count zero, degree -1) and drops any
// pending result; the memory itself is not cleared.
// A stalled receiver holds the result register. The block accepts a new word
// while a result waits only if that result is taken in the same cycle, and a
// finished scan waits in place until the result register is free.
module polynomial_term_table
    import ptt_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic [EXP_W-1:0]            i_term_exponent,
    input  logic signed [COEF_W-1:0]    i_term_coefficient,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [COEF_W-1:0]    o_coefficient_out,
    output logic                        o_found,
    output logic [1:0]                  o_status,
    output logic signed [DEG_W-1:0]     o_degree,
    output logic [CNT_OUT_W-1:0]        o_term_count
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int ENT_W = EXP_W + COEF_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_TERMS);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // Control and payload registers.
    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic signed [DEG_W-1:0]    r_degree, n_degree;
    logic [IDX_W-1:0]           r_idx, n_idx;
    t_mode                      r_mode, n_mode;
    logic [EXP_W-1:0]           r_exp, n_exp;
    logic signed [COEF_W-1:0]   r_coef, n_coef;

    // Result register.
    logic                       r_out_valid, n_out_valid;
    logic signed [COEF_W-1:0]   r_out_coef, n_out_coef;
    logic                       r_out_found, n_out_found;
    t_status                    r_out_status, n_out_status;
    logic signed [DEG_W-1:0]    r_out_degree, n_out_degree;
    logic [CNT_W-1:0]           r_out_count, n_out_count;

    // Memory port signals.
    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;
    logic [ENT_W-1:0]           w_wdata;
    logic                       w_re;
    logic [IDX_W-1:0]           w_raddr;
    logic [ENT_W-1:0]           w_rdata;
    logic [EXP_W-1:0]           w_rd_exp;
    logic signed [COEF_W-1:0]   w_rd_coef;

    logic                       w_slot_free;
    logic                       w_in_fire;
    logic                       w_done;
    logic                       w_last;
    logic [CNT_W+CNT_OUT_W-1:0] w_cnt_ext;

    // Each entry holds the exponent above the coefficient.
    ptt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TERMS)
    ) u_terms (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_exp  = w_rdata[ENT_W-1:COEF_W];
    assign w_rd_coef = w_rdata[COEF_W-1:0];

    // The result register can take a new result this cycle.
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_in_fire   = i_in_valid && o_in_ready;

    // The entry now on the read port is the newest stored one.
    assign w_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    // Sequencer and next-state logic.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_degree     = r_degree;
        n_idx        = r_idx;
        n_mode       = r_mode;
        n_exp        = r_exp;
        n_coef       = r_coef;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_coef   = r_out_coef;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_degree = r_out_degree;
        n_out_count  = r_out_count;
        w_done       = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_count[IDX_W-1:0];
        w_wdata      = {i_term_exponent, i_term_coefficient};
        w_re         = 1'b0;
        w_raddr      = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_mode = i_mode;
                    n_exp  = i_term_exponent;
                    n_coef = i_term_coefficient;
                    case (i_mode)
                        MODE_APPEND: begin
                            w_done       = 1'b1;
                            n_out_coef   = '0;
                            n_out_found  = 1'b0;
                            if (r_count == FULL_COUNT) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_OK;
                                w_we         = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                                if ($signed({1'b0, i_term_exponent}) > r_degree) begin
                                    n_degree = $signed({1'b0, i_term_exponent});
                                end
                            end
                        end
                        MODE_LOOKUP, MODE_CHANGE: begin
                            if (r_count == '0) begin
                                w_done       = 1'b1;
                                n_out_coef   = '0;
                                n_out_found  = 1'b0;
                                n_out_status = ST_NOMATCH;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            w_done       = 1'b1;
                            n_out_coef   = '0;
                            n_out_found  = 1'b0;
                            n_out_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Stall with the read data held until the result slot is free.
                if (w_slot_free) begin
                    if (w_rd_exp == r_exp) begin
                        w_done       = 1'b1;
                        n_out_found  = 1'b1;
                        n_out_status = ST_OK;
                        n_out_coef   = (r_mode == MODE_LOOKUP) ? w_rd_coef : '0;
                        if (r_mode == MODE_CHANGE) begin
                            w_we    = 1'b1;
                            w_waddr = r_idx;
                            w_wdata = {r_exp, r_coef};
                        end
                        n_state = S_IDLE;
                    end else if (w_last) begin
                        w_done       = 1'b1;
                        n_out_found  = 1'b0;
                        n_out_status = ST_NOMATCH;
                        n_out_coef   = '0;
                        n_state      = S_IDLE;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = r_idx + IDX_W'(1);
                        n_idx   = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Every result carries the table state after its operation.
        if (w_done) begin
            n_out_valid  = 1'b1;
            n_out_degree = n_degree;
            n_out_count  = n_count;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_degree    <= DEG_EMPTY;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_degree    <= n_degree;
        end
        r_idx        <= n_idx;
        r_mode       <= n_mode;
        r_exp        <= n_exp;
        r_coef       <= n_coef;
        r_out_coef   <= n_out_coef;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_out_degree <= n_out_degree;
        r_out_count  <= n_out_count;
    end

    // The count is reported modulo 128.
    assign w_cnt_ext = {{CNT_OUT_W{1'b0}}, r_out_count};

    assign o_out_valid       = r_out_valid;
    assign o_coefficient_out = r_out_coef;
    assign o_found           = r_out_found;
    assign o_status          = r_out_status;
    assign o_degree          = r_out_degree;
    assign o_term_count      = w_cnt_ext[CNT_OUT_W-1:0];

endmodule

/* rtl/ptt_checker.sv */
// Port-level checker of the polynomial term table, bound to the top level.
// Depends on ptt_pkg and polynomial_term_table_assert.svh.
`include "polynomial_term_table_assert.svh"

module ptt_checker
    import ptt_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [COEF_W-1:0] o_coefficient_out,
    input logic                     o_found,
    input logic [1:0]               o_status,
    input logic signed [DEG_W-1:0]  o_degree,
    input logic [CNT_OUT_W-1:0]     o_term_count
);

    // A result word stays until it is taken.
    `PTT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

    // A new word is taken only when the pending result leaves in the same cycle.
    `PTT_ASSERT_NOW(a_no_overrun, o_in_ready && o_out_valid, i_out_ready, "result overrun")

    // A match always reports success.
    `PTT_ASSERT_NOW(a_found_ok, o_out_valid && o_found, o_status == ST_OK, "found without ok")

    // A refused append carries no coefficient and no match.
    `PTT_ASSERT_NOW(a_full_clean, o_out_valid && (o_status == ST_FULL),
        !o_found && (o_coefficient_out == '0), "full result not clean")

    // An empty table has no degree.
    `PTT_ASSERT_NOW(a_empty_deg, o_out_valid && (MAX_TERMS < 128) && (o_term_count == '0),
        o_degree == DEG_EMPTY, "empty table with a degree")

endmodule

bind polynomial_term_table ptt_checker #(.MAX_TERMS(MAX_TERMS)) u_ptt_checker (.*);
